// ===== sv/owmq_pkg.sv =====
// owmq_pkg: shared types and constants of the overwrite-oldest message queue
// no dependencies; used by the channel interfaces, the ring and the top level
package owmq_pkg;

  localparam int TOTAL_BITS = 32;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_TICK    = 1'b1
  } action_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_status_t;

endpackage

// ===== sv/owmq_in_if.sv =====
// owmq_in_if: valid/ready channel carrying enqueue and tick items
// depends on owmq_pkg for the action type
interface owmq_in_if #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  owmq_pkg::action_t       action;
  logic [PAYLOAD_BITS-1:0] payload;
  logic                    payload_ok;
  logic                    link_ready;
  logic                    send_taken;

  modport source (
    output valid, action, payload, payload_ok, link_ready, send_taken,
    input  ready
  );
  modport sink (
    input  valid, action, payload, payload_ok, link_ready, send_taken,
    output ready
  );
endinterface

// ===== sv/owmq_out_if.sv =====
// owmq_out_if: valid/ready channel carrying one result per item
// depends on owmq_pkg for the counter width
interface owmq_out_if #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 64
);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                            valid;
  logic                            ready;
  logic                            success;
  logic                            send_strobe;
  logic [PAYLOAD_BITS-1:0]         head_payload;
  logic [CNT_W-1:0]                queued_count;
  logic [owmq_pkg::TOTAL_BITS-1:0] dropped_count;
  logic [owmq_pkg::TOTAL_BITS-1:0] sent_count;
  logic [owmq_pkg::TOTAL_BITS-1:0] revision_count;

  modport source (
    output valid, success, send_strobe, head_payload, queued_count,
           dropped_count, sent_count, revision_count,
    input  ready
  );
  modport sink (
    input  valid, success, send_strobe, head_payload, queued_count,
           dropped_count, sent_count, revision_count,
    output ready
  );
endinterface

// ===== sv/owmq_ring.sv =====
// owmq_ring: message ring memory with head pointer and fill level
// depends on owmq_pkg for the command and status structs
module owmq_ring #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 64,
  parameter int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  owmq_pkg::ring_cmd_t     cmd,
  input  logic [PAYLOAD_BITS-1:0] wr_data,
  output owmq_pkg::ring_status_t  status,
  output logic [CNT_W-1:0]        fill_nxt,
  output logic [PAYLOAD_BITS-1:0] head_data
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = CNT_W + 1;

  logic [PAYLOAD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] head_data_r;
  logic [AW-1:0]           head_r, head_nxt, head_adv, wr_addr;
  logic [CNT_W-1:0]        fill_r, fill_base;
  logic [SW-1:0]           slot_sum, slot;
  logic                    drop;

  always_comb begin
    status.full  = (fill_r == CNT_W'(QUEUE_DEPTH));
    status.empty = (fill_r == '0);
    drop      = cmd.push && status.full;
    head_adv  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    head_nxt  = (drop || cmd.pop) ? head_adv : head_r;
    fill_base = drop ? fill_r - CNT_W'(1) : fill_r;
    slot_sum  = SW'(head_nxt) + SW'(fill_base);
    slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ? slot_sum - SW'(QUEUE_DEPTH) : slot_sum;
    wr_addr   = slot[AW-1:0];
    if (cmd.push) begin
      fill_nxt = fill_base + CNT_W'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // head read tracks the next head, with write bypass
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.push && (wr_addr == head_nxt)) begin
      head_data_r <= wr_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign head_data = head_data_r;

endmodule

// ===== sv/overwrite_oldest_message_queue_unit.sv =====
// overwrite_oldest_message_queue_unit: ring queue that drops its oldest message when full
// depends on owmq_pkg, owmq_in_if, owmq_out_if and owmq_ring
//
//   channel  | direction | transfer moves
//   in_ch    | sink      | enqueue (payload, payload_ok) or tick (link_ready, send_taken)
//   out_ch   | source    | success, strobe, head payload, fill level, three totals
//
// one item per cycle while results are taken; its result is registered and shows the cycle after the transfer
// the head message is read ahead into a register from the ring memory, bypassed on write
// rst_n clears pointers, fill level, totals and the result valid; messages are not cleared
// a stalled result holds and blocks new items until it is taken
module overwrite_oldest_message_queue_unit #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  owmq_in_if.sink     in_ch,
  owmq_out_if.source  out_ch
);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = owmq_pkg::TOTAL_BITS;

  owmq_pkg::ring_cmd_t     cmd;
  owmq_pkg::ring_status_t  status;
  logic [CNT_W-1:0]        fill_nxt;
  logic [PAYLOAD_BITS-1:0] head_data;
  logic                    accept, strobe, drop;

  logic [TW-1:0] drop_r, drop_nxt, send_r, send_nxt, change_r, change_nxt;

  logic                    out_valid_r;
  logic                    out_success_r;
  logic                    out_strobe_r;
  logic [PAYLOAD_BITS-1:0] out_head_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [TW-1:0]           out_drop_r, out_send_r, out_change_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd.push = accept && (in_ch.action == owmq_pkg::ACT_ENQUEUE) && in_ch.payload_ok;
    strobe   = accept && (in_ch.action == owmq_pkg::ACT_TICK) && !status.empty
               && in_ch.link_ready;
    cmd.pop  = strobe && in_ch.send_taken;
    drop     = cmd.push && status.full;
    drop_nxt   = drop ? drop_r + TW'(1) : drop_r;
    send_nxt   = cmd.pop ? send_r + TW'(1) : send_r;
    change_nxt = (cmd.push || cmd.pop) ? change_r + TW'(1) : change_r;
  end

  owmq_ring #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .CNT_W        (CNT_W)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_data   (in_ch.payload),
    .status    (status),
    .fill_nxt  (fill_nxt),
    .head_data (head_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r      <= '0;
      send_r      <= '0;
      change_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      drop_r   <= drop_nxt;
      send_r   <= send_nxt;
      change_r <= change_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_success_r <= cmd.push || (cmd.pop && (fill_nxt != '0));
      out_strobe_r  <= strobe;
      out_head_r    <= strobe ? head_data : '0;
      out_count_r   <= fill_nxt;
      out_drop_r    <= drop_nxt;
      out_send_r    <= send_nxt;
      out_change_r  <= change_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.success        = out_success_r;
  assign out_ch.send_strobe    = out_strobe_r;
  assign out_ch.head_payload   = out_head_r;
  assign out_ch.queued_count   = out_count_r;
  assign out_ch.dropped_count  = out_drop_r;
  assign out_ch.sent_count     = out_send_r;
  assign out_ch.revision_count = out_change_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= CNT_W'(QUEUE_DEPTH)))
    else $error("queued count above capacity");

  a_drop_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop |=> (out_count_r == CNT_W'(QUEUE_DEPTH)) && (drop_r == $past(drop_r) + TW'(1)))
    else $error("overflow drop did not keep the queue full");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (send_r == $past(send_r) + TW'(1)) && out_strobe_r)
    else $error("accepted send not counted");

  a_idle_revision: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push || cmd.pop) |=> (change_r == $past(change_r)))
    else $error("revision changed without a stored or sent message");

endmodule
